/* design/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cond holds whenever trig holds, in the same cycle.
`define CHK_IMPL(lbl, trig, cond) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |-> (cond)) \
        else $error("assertion failed");

// Check that cond holds in the cycle after trig holds.
`define CHK_NEXT(lbl, trig, cond) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (cond)) \
        else $error("assertion failed");

`endif

/* design/ihex_pkg.sv */
package ihex_pkg;

    localparam int RECORD_BYTES_DEF = 32;

    localparam int LEN_W = 6;
    localparam logic [LEN_W-1:0] LEN_RESET = 6'd32;

    localparam int PADDR_W = 3;
    localparam logic REG_LENGTH = 1'b0;

    localparam logic CMD_DATA = 1'b0;
    localparam logic CMD_EOF  = 1'b1;

    localparam logic [7:0] TYPE_DATA = 8'h00;
    localparam logic [7:0] TYPE_EOF  = 8'h01;
    localparam logic [7:0] TYPE_EXT  = 8'h04;
    localparam logic [7:0] EXT_LEN   = 8'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HEAD,
        ST_DATA,
        ST_SUM
    } state_t;

    typedef enum logic [1:0] {
        REC_EXT,
        REC_DATA,
        REC_EOF
    } rec_kind_t;

    typedef struct packed {
        logic       load;
        logic [7:0] value;
        logic       first;
        logic       rec_last;
        logic       tlast;
        logic       use_sum;
    } emit_ctrl_t;

    function automatic logic [6:0] hex_digit(input logic [3:0] nib);
        if (nib < 4'd10) begin
            return 7'd48 + {3'b000, nib};
        end
        return 7'd55 + {3'b000, nib};
    endfunction

endpackage

/* design/ihex_buffer.sv */
module ihex_buffer #(
    parameter int DEPTH = ihex_pkg::RECORD_BYTES_DEF,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* design/ihex_byte_unit.sv */
module ihex_byte_unit (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  ihex_pkg::emit_ctrl_t   ctrl,
    output logic                   free,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [15:0]            m_tdata,   // hex_high[6:0], hex_low[13:7], zero pad
    output logic [1:0]             m_tuser,   // record_first[0], record_last[1]
    output logic                   m_tlast
);

    logic       valid_reg, valid_next;
    logic [7:0] sum_reg, sum_next;
    logic [6:0] hi_reg, lo_reg;
    logic       first_reg, rec_last_reg, tlast_reg;
    logic [7:0] value_sel;

    always_comb begin
        free       = !valid_reg || m_tready;
        value_sel  = ctrl.use_sum ? (8'd0 - sum_reg) : ctrl.value;
        sum_next   = sum_reg;
        valid_next = valid_reg;
        if (m_tready) begin
            valid_next = 1'b0;
        end
        if (ctrl.load) begin
            valid_next = 1'b1;
            sum_next   = ctrl.first ? ctrl.value : sum_reg + ctrl.value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sum_reg <= sum_next;
        if (ctrl.load) begin
            hi_reg       <= ihex_pkg::hex_digit(value_sel[7:4]);
            lo_reg       <= ihex_pkg::hex_digit(value_sel[3:0]);
            first_reg    <= ctrl.first;
            rec_last_reg <= ctrl.rec_last;
            tlast_reg    <= ctrl.tlast;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {2'b00, lo_reg, hi_reg};
    assign m_tuser  = {rec_last_reg, first_reg};
    assign m_tlast  = tlast_reg;

endmodule

/* design/intel_hex_record_encoder.sv */
// Channel   Direction  Payload
// s_        in         tdata: data_byte, section_base; tuser: cmd, section_start; tlast: end
// m_        out        tdata: hex_high, hex_low; tuser: record_first, record_last; tlast: last
// APB       in         record_length at byte address 0
//
// A data byte that closes no record leaves the sequencer idle and s_tready high.
// A closing byte or end of file holds s_tready low while the record bytes leave the output
// register, one per cycle: 5 + n for a data record of n bytes, 7 more for a type-04 record,
// 5 for the end record. The byte sequencer and the shared checksum and hex unit set this.
// A stall on m_tready holds the sequencer. Reset clears control state; the buffer is not cleared.
module intel_hex_record_encoder #(
    parameter int RECORD_BYTES = ihex_pkg::RECORD_BYTES_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [39:0]                  s_tdata,   // data_byte[7:0], section_base[39:8]
    input  logic [1:0]                   s_tuser,   // cmd[0], section_start[1]
    input  logic                         s_tlast,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [15:0]                  m_tdata,   // hex_high[6:0], hex_low[13:7]
    output logic [1:0]                   m_tuser,   // record_first[0], record_last[1]
    output logic                         m_tlast,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ihex_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    localparam int AW = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1;
    localparam int CW = $clog2(RECORD_BYTES + 1);
    localparam logic [7:0] RB8 = 8'(RECORD_BYTES);

    ihex_pkg::state_t    state_reg, state_next;
    ihex_pkg::rec_kind_t kind_reg, kind_next;
    logic [1:0]          idx_reg, idx_next;
    logic [CW-1:0]       ptr_reg, ptr_next;
    logic                eof_reg, eof_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [31:0]         rec_addr_reg, rec_addr_next;
    logic [31:0]         next_addr_reg, next_addr_next;
    logic [15:0]         upper_reg, upper_next;
    logic [ihex_pkg::LEN_W-1:0] length_reg, length_next;

    ihex_pkg::emit_ctrl_t ctrl;
    logic                 free;
    logic                 accept;
    logic                 cfg_wr;
    logic [CW-1:0]        cnt0, cnt1;
    logic [31:0]          na, na1, ra;
    logic [7:0]           limit8, len8, body_len8;
    logic                 close;
    logic                 wr_en;
    logic [7:0]           rd_data;
    logic [15:0]          addr16;
    logic [7:0]           type8;

    assign cfg_wr = psel && penable && pwrite && pready;
    assign accept = s_tvalid && s_tready;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == ihex_pkg::REG_LENGTH) ?
                    {{(32 - ihex_pkg::LEN_W){1'b0}}, length_reg} : 32'd0;

    always_comb begin
        length_next = length_reg;
        if (cfg_wr && paddr[2] == ihex_pkg::REG_LENGTH) begin
            length_next = pwdata[ihex_pkg::LEN_W-1:0];
        end
    end

    always_comb begin
        len8   = 8'(length_reg);
        limit8 = len8;
        if (len8 == 8'd0) begin
            limit8 = 8'd1;
        end else if (len8 > RB8) begin
            limit8 = RB8;
        end
        cnt0  = s_tuser[1] ? '0 : count_reg;
        na    = s_tuser[1] ? s_tdata[39:8] : next_addr_reg;
        ra    = (cnt0 == '0) ? na : rec_addr_reg;
        cnt1  = (8'(cnt0) < RB8) ? cnt0 + 1'b1 : cnt0;
        na1   = na + 32'd1;
        close = (8'(cnt1) >= limit8) || (na1[15:0] == 16'd0) || s_tlast;
        wr_en = accept && (s_tuser[0] == ihex_pkg::CMD_DATA) && (8'(cnt0) < RB8);
    end

    always_comb begin
        case (kind_reg)
            ihex_pkg::REC_EXT: begin
                body_len8 = ihex_pkg::EXT_LEN;
                addr16    = 16'd0;
                type8     = ihex_pkg::TYPE_EXT;
            end
            ihex_pkg::REC_DATA: begin
                body_len8 = 8'(count_reg);
                addr16    = rec_addr_reg[15:0];
                type8     = ihex_pkg::TYPE_DATA;
            end
            default: begin
                body_len8 = 8'd0;
                addr16    = 16'd0;
                type8     = ihex_pkg::TYPE_EOF;
            end
        endcase
    end

    always_comb begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        idx_next       = idx_reg;
        ptr_next       = ptr_reg;
        eof_next       = eof_reg;
        count_next     = count_reg;
        rec_addr_next  = rec_addr_reg;
        next_addr_next = next_addr_reg;
        upper_next     = upper_reg;
        case (state_reg)
            ihex_pkg::ST_IDLE: begin
                if (accept) begin
                    idx_next = 2'd0;
                    ptr_next = '0;
                    if (s_tuser[0] == ihex_pkg::CMD_EOF) begin
                        eof_next   = 1'b1;
                        state_next = ihex_pkg::ST_HEAD;
                        if (count_reg == '0) begin
                            kind_next = ihex_pkg::REC_EOF;
                        end else if (rec_addr_reg[31:16] != upper_reg) begin
                            kind_next  = ihex_pkg::REC_EXT;
                            upper_next = rec_addr_reg[31:16];
                        end else begin
                            kind_next = ihex_pkg::REC_DATA;
                        end
                    end else begin
                        eof_next       = 1'b0;
                        count_next     = cnt1;
                        next_addr_next = na1;
                        rec_addr_next  = ra;
                        if (close) begin
                            state_next = ihex_pkg::ST_HEAD;
                            if (ra[31:16] != upper_reg) begin
                                kind_next  = ihex_pkg::REC_EXT;
                                upper_next = ra[31:16];
                            end else begin
                                kind_next = ihex_pkg::REC_DATA;
                            end
                        end
                    end
                end
            end
            ihex_pkg::ST_HEAD: begin
                if (free) begin
                    idx_next = idx_reg + 2'd1;
                    ptr_next = '0;
                    if (idx_reg == 2'd3) begin
                        state_next = (body_len8 == 8'd0) ? ihex_pkg::ST_SUM : ihex_pkg::ST_DATA;
                    end
                end
            end
            ihex_pkg::ST_DATA: begin
                if (free) begin
                    ptr_next = ptr_reg + 1'b1;
                    if (8'(ptr_reg) == body_len8 - 8'd1) begin
                        state_next = ihex_pkg::ST_SUM;
                    end
                end
            end
            ihex_pkg::ST_SUM: begin
                if (free) begin
                    idx_next = 2'd0;
                    ptr_next = '0;
                    case (kind_reg)
                        ihex_pkg::REC_EXT: begin
                            kind_next  = ihex_pkg::REC_DATA;
                            state_next = ihex_pkg::ST_HEAD;
                        end
                        ihex_pkg::REC_DATA: begin
                            count_next = '0;
                            if (eof_reg) begin
                                kind_next  = ihex_pkg::REC_EOF;
                                state_next = ihex_pkg::ST_HEAD;
                            end else begin
                                state_next = ihex_pkg::ST_IDLE;
                            end
                        end
                        default: begin
                            state_next = ihex_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            default: begin
                state_next = ihex_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready      = (state_reg == ihex_pkg::ST_IDLE);
        ctrl          = '0;
        ctrl.load     = (state_reg != ihex_pkg::ST_IDLE) && free;
        case (state_reg)
            ihex_pkg::ST_HEAD: begin
                ctrl.first = (idx_reg == 2'd0);
                case (idx_reg)
                    2'd0:    ctrl.value = body_len8;
                    2'd1:    ctrl.value = addr16[15:8];
                    2'd2:    ctrl.value = addr16[7:0];
                    default: ctrl.value = type8;
                endcase
            end
            ihex_pkg::ST_DATA: begin
                if (kind_reg == ihex_pkg::REC_EXT) begin
                    ctrl.value = (ptr_reg == '0) ? upper_reg[15:8] : upper_reg[7:0];
                end else begin
                    ctrl.value = rd_data;
                end
            end
            ihex_pkg::ST_SUM: begin
                ctrl.use_sum  = 1'b1;
                ctrl.rec_last = 1'b1;
                ctrl.tlast    = (kind_reg == ihex_pkg::REC_EOF) ||
                                ((kind_reg == ihex_pkg::REC_DATA) && !eof_reg);
            end
            default: begin
                ctrl.load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ihex_pkg::ST_IDLE;
            kind_reg      <= ihex_pkg::REC_DATA;
            idx_reg       <= 2'd0;
            ptr_reg       <= '0;
            eof_reg       <= 1'b0;
            count_reg     <= '0;
            rec_addr_reg  <= 32'd0;
            next_addr_reg <= 32'd0;
            upper_reg     <= 16'd0;
            length_reg    <= ihex_pkg::LEN_RESET;
        end else begin
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            idx_reg       <= idx_next;
            ptr_reg       <= ptr_next;
            eof_reg       <= eof_next;
            count_reg     <= count_next;
            rec_addr_reg  <= rec_addr_next;
            next_addr_reg <= next_addr_next;
            upper_reg     <= upper_next;
            length_reg    <= length_next;
        end
    end

    ihex_buffer #(
        .DEPTH(RECORD_BYTES)
    ) u_buffer (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (cnt0[AW-1:0]),
        .wr_data (s_tdata[7:0]),
        .rd_addr (ptr_next[AW-1:0]),
        .rd_data (rd_data)
    );

    ihex_byte_unit u_byte_unit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (ctrl),
        .free     (free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

/* design/ihex_checker.sv */
`include "assert_macros.svh"

module ihex_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic [39:0]                  s_tdata,
    input logic [1:0]                   s_tuser,
    input logic                         s_tlast,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [15:0]                  m_tdata,
    input logic [1:0]                   m_tuser,
    input logic                         m_tlast,
    input logic                         psel,
    input logic                         penable,
    input logic                         pwrite,
    input logic [ihex_pkg::PADDR_W-1:0] paddr,
    input logic [31:0]                  pwdata,
    input logic [31:0]                  prdata,
    input logic                         pready
);

    `CHK_NEXT(a_m_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    `CHK_NEXT(a_rec_first, m_tvalid && m_tready && m_tuser[1], !m_tvalid || m_tuser[0])
    `CHK_IMPL(a_last_on_sum, m_tvalid && m_tlast, m_tuser[1])
    `CHK_IMPL(a_busy, m_tvalid && !m_tlast, !s_tready)
    `CHK_IMPL(a_hex_digit, m_tvalid, (m_tdata[6:0] >= 7'd48 && m_tdata[6:0] <= 7'd57) || (m_tdata[6:0] >= 7'd65 && m_tdata[6:0] <= 7'd70))

endmodule

bind intel_hex_record_encoder ihex_checker u_ihex_checker (.*);
